FILE: rtl/wspl_pkg.sv
package wspl_pkg;

	// default elaboration values
	localparam int HISTORY_DEPTH_DEF = 8;
	localparam int COUNTER_BITS_DEF  = 16;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// fixed field widths
	localparam int GAIN_W   = 16;
	localparam int ILIM_W   = 24;
	localparam int MOD_W    = 17;
	localparam int SPEED_W  = 16;
	localparam int DRIVE_W  = 17;
	localparam int ERR_W    = 18;
	localparam int DERR_W   = 19;
	localparam int ACC_W    = 25;
	localparam int MUL_A_W  = GAIN_W + 1;
	localparam int MUL_B_W  = ACC_W + 1;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int PSUM_W   = MUL_P_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_GAIN         = 3'd0,
		REG_KI_GAIN         = 3'd1,
		REG_KD_GAIN         = 3'd2,
		REG_DRIVE_LIMIT     = 3'd3,
		REG_INTEGRAL_LIMIT  = 3'd4,
		REG_ENCODER_MODULUS = 3'd5,
		REG_SPEED_SCALE     = 3'd6
	} wspl_reg_t;

	// register reset values
	localparam logic [GAIN_W-1:0] KP_RESET    = 16'd2048;
	localparam logic [GAIN_W-1:0] KI_RESET    = 16'd64;
	localparam logic [GAIN_W-1:0] KD_RESET    = 16'd9600;
	localparam logic [GAIN_W-1:0] DLIM_RESET  = 16'd0;
	localparam logic [ILIM_W-1:0] ILIM_RESET  = 24'd0;
	localparam logic [MOD_W-1:0]  MOD_RESET   = 17'd65536;
	localparam logic [GAIN_W-1:0] SCALE_RESET = 16'd256;

endpackage

FILE: rtl/wspl_sample_if.sv
interface wspl_sample_if import wspl_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic        [15:0]        encoder_count;
	logic signed [SPEED_W-1:0] speed_setpoint;

	modport source (output valid, output encoder_count, output speed_setpoint, input ready);
	modport sink (input valid, input encoder_count, input speed_setpoint, output ready);
endinterface

FILE: rtl/wspl_result_if.sv
interface wspl_result_if import wspl_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      direction_forward;
	logic        [15:0]        duty;
	logic signed [DRIVE_W-1:0] drive_value;
	logic signed [SPEED_W-1:0] measured_speed;

	modport source (output valid, output direction_forward, output duty, output drive_value,
		output measured_speed, input ready);
	modport sink (input valid, input direction_forward, input duty, input drive_value,
		input measured_speed, output ready);
endinterface

FILE: rtl/wheel_speed_pid_loop.sv
// a result is loaded into the output register in S_OUT, once the output register is free, after the
//   sequencer has walked S_SCALE, S_HIST, S_ABS, S_RECIP, S_MEAS, S_ERR and S_M0 to S_M3; one sample is
//   in flight at a time, through the history ring read/write, the reciprocal multiply and the shared gain multiplier
// a result waiting in the output register does not block the next sample
// reset (arst_n low, asynchronous): registers to defaults, state cleared, history
//   valid bits cleared at once so the ring reads as zero; no clearing pass
module wheel_speed_pid_loop import wspl_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int COUNTER_BITS  = COUNTER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	wspl_sample_if.sink           sample,
	wspl_result_if.source         result
);

	// derived sizes
	localparam int CB    = COUNTER_BITS;
	localparam int LD    = $clog2(HISTORY_DEPTH);
	localparam int PTR_W = (LD < 1) ? 1 : LD;
	localparam int SW    = SPEED_W + LD;          // history sum width
	localparam int MW    = (CB + 1 > MOD_W) ? CB + 1 : MOD_W;
	localparam int DW    = CB + 2;                // raw difference width
	localparam int PW    = CB + 1 + GAIN_W + 1;   // scaled count product width
	localparam int RK    = SW + LD;               // reciprocal shift
	localparam int QW    = 2 * SW + 1;            // reciprocal product width
	// exact floor division by the history depth for operands below 2^SW
	localparam logic [SW:0] RECIP = (SW + 1)'(((64'd1 << RK) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);
	localparam logic signed [PW-1:0] RAW_MAX = PW'(32767);
	localparam logic signed [PW-1:0] RAW_MIN = PW'(-32768);

	typedef enum logic [3:0] {
		S_IDLE, S_SCALE, S_HIST, S_ABS, S_RECIP, S_MEAS, S_ERR,
		S_M0, S_M1, S_M2, S_M3, S_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [GAIN_W-1:0] kp_q, ki_q, kd_q, dlim_q, scale_q;
	logic [ILIM_W-1:0] ilim_q;
	logic [MOD_W-1:0]  mod_q;

	// loop state
	logic        [CB-1:0]      last_count_q;
	logic signed [SW-1:0]      hsum_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ERR_W-1:0]   prev_err_q;
	logic        [PTR_W-1:0]   ptr_q;
	logic [HISTORY_DEPTH-1:0]  hist_vld_q;
	logic                      out_vld_q;

	// working registers of the sequencer
	logic signed [CB:0]         delta_q;
	logic signed [SPEED_W-1:0]  target_q;
	logic signed [PW-1:0]       scaled_q;
	logic signed [SPEED_W-1:0]  rd_data_q;
	logic                       rd_vld_q;
	logic        [SW-1:0]       x_q;
	logic                       neg_q;
	logic        [QW-1:0]       qprod_q;
	logic signed [SPEED_W-1:0]  measured_q;
	logic signed [ERR_W-1:0]    err_q;
	logic signed [DERR_W-1:0]   derr_q;
	logic                       zero_q;
	logic signed [MUL_P_W-1:0]  mul_q;
	logic signed [PSUM_W-1:0]   psum_q;

	// output payload
	logic                       dir_q;
	logic        [15:0]         duty_q;
	logic signed [DRIVE_W-1:0]  drive_q;
	logic signed [SPEED_W-1:0]  meas_out_q;

	// history ring memory, one read or one write per cycle
	logic signed [SPEED_W-1:0] hist_mem [HISTORY_DEPTH];

	logic sample_beat;
	logic out_free;
	logic out_load;

	assign sample.ready = (state_q == S_IDLE);
	assign sample_beat  = sample.valid && sample.ready;
	assign out_free     = !out_vld_q || result.ready;
	assign out_load     = (state_q == S_OUT) && out_free;

	assign result.valid             = out_vld_q;
	assign result.direction_forward = dir_q;
	assign result.duty              = duty_q;
	assign result.drive_value       = drive_q;
	assign result.measured_speed    = meas_out_q;

	// ---- count difference with a single wrap correction ----
	logic [CB+15:0]      cnt_wide;
	logic [CB-1:0]       cnt_in;
	logic [MW-1:0]       mod_ext, full_ext, m_sel;
	logic [CB:0]         m_eff, half;
	logic signed [DW-1:0] d0, d1, half_s, m_s;

	always_comb begin
		cnt_wide = {{CB{1'b0}}, sample.encoder_count};
		cnt_in   = cnt_wide[CB-1:0];
		mod_ext  = MW'(mod_q);
		full_ext = MW'(1) << CB;
		// out-of-range modulus falls back to the full counter span
		m_sel    = (mod_ext < MW'(2) || mod_ext > full_ext) ? full_ext : mod_ext;
		m_eff    = m_sel[CB:0];
		half     = m_eff >> 1;
		half_s   = $signed({1'b0, half});
		m_s      = $signed({1'b0, m_eff});
		d0       = $signed({2'b00, cnt_in}) - $signed({2'b00, last_count_q});
		if (d0 > half_s) begin
			d1 = d0 - m_s;
		end else if (d0 < -half_s) begin
			d1 = d0 + m_s;
		end else begin
			d1 = d0;
		end
	end

	// ---- raw speed saturation and history sum update ----
	logic signed [PW-1:0]      raw_sh;
	logic signed [SPEED_W-1:0] raw;
	logic signed [SPEED_W-1:0] hist_old;
	logic signed [SW:0]        hsum_w;
	logic signed [SW:0]        xw;

	always_comb begin
		raw_sh = scaled_q >>> 8;
		if (raw_sh > RAW_MAX) begin
			raw = SPEED_W'(RAW_MAX);
		end else if (raw_sh < RAW_MIN) begin
			raw = SPEED_W'(RAW_MIN);
		end else begin
			raw = raw_sh[SPEED_W-1:0];
		end
		hist_old = rd_vld_q ? rd_data_q : '0;
		hsum_w   = (SW + 1)'(hsum_q) - (SW + 1)'(hist_old) + (SW + 1)'(raw);
		// floor of a negative sum: negate, round up, divide, negate back
		xw       = -(SW + 1)'(hsum_q) + (SW + 1)'(HISTORY_DEPTH - 1);
	end

	// ---- mean and error terms ----
	logic        [16:0]         q17;
	logic        [16:0]         mq;
	logic signed [ERR_W-1:0]    err_n;

	always_comb begin
		q17   = qprod_q[RK+16:RK];
		mq    = neg_q ? -q17 : q17;
		err_n = ERR_W'(target_q) - ERR_W'(measured_q);
	end

	// ---- accumulator clamp ----
	logic signed [MUL_B_W-1:0] acc_w, acc_lim, acc_n;

	always_comb begin
		acc_w   = (zero_q ? '0 : MUL_B_W'(acc_q)) + MUL_B_W'(err_q);
		acc_lim = $signed({2'b00, ilim_q});
		if (acc_w > acc_lim) begin
			acc_n = acc_lim;
		end else if (acc_w < -acc_lim) begin
			acc_n = -acc_lim;
		end else begin
			acc_n = acc_w;
		end
	end

	// ---- shared gain multiplier, one term per cycle ----
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;

	always_comb begin
		case (state_q)
			S_M0: begin
				mul_a = $signed({1'b0, kp_q});
				mul_b = MUL_B_W'(err_q);
			end
			S_M1: begin
				mul_a = $signed({1'b0, ki_q});
				mul_b = MUL_B_W'(acc_q);
			end
			S_M2: begin
				mul_a = $signed({1'b0, kd_q});
				mul_b = MUL_B_W'(derr_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// ---- drive clamp ----
	logic signed [PSUM_W-1:0]  dsh, dlim_s, dcl;
	logic signed [DRIVE_W-1:0] drive_n;
	logic signed [DRIVE_W-1:0] drive_abs;

	always_comb begin
		dsh    = psum_q >>> 8;
		dlim_s = $signed({{(PSUM_W - GAIN_W){1'b0}}, dlim_q});
		if (dsh > dlim_s) begin
			dcl = dlim_s;
		end else if (dsh < -dlim_s) begin
			dcl = -dlim_s;
		end else begin
			dcl = dsh;
		end
		drive_n   = dcl[DRIVE_W-1:0];
		drive_abs = (drive_n < 0) ? -drive_n : drive_n;
	end

	// ---- control, configuration and loop state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kp_q         <= KP_RESET;
			ki_q         <= KI_RESET;
			kd_q         <= KD_RESET;
			dlim_q       <= DLIM_RESET;
			ilim_q       <= ILIM_RESET;
			mod_q        <= MOD_RESET;
			scale_q      <= SCALE_RESET;
			last_count_q <= '0;
			hsum_q       <= '0;
			acc_q        <= '0;
			prev_err_q   <= '0;
			ptr_q        <= '0;
			hist_vld_q   <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KP_GAIN:         kp_q    <= cfg_data[GAIN_W-1:0];
					REG_KI_GAIN:         ki_q    <= cfg_data[GAIN_W-1:0];
					REG_KD_GAIN:         kd_q    <= cfg_data[GAIN_W-1:0];
					REG_DRIVE_LIMIT:     dlim_q  <= cfg_data[GAIN_W-1:0];
					REG_INTEGRAL_LIMIT:  ilim_q  <= cfg_data[ILIM_W-1:0];
					REG_ENCODER_MODULUS: mod_q   <= cfg_data[MOD_W-1:0];
					REG_SPEED_SCALE:     scale_q <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end

			// a new result wins over the beat leaving in the same cycle
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (sample_beat) begin
						last_count_q <= cnt_in;
						state_q      <= S_SCALE;
					end
				end
				S_SCALE: state_q <= S_HIST;
				S_HIST: begin
					// oldest entry leaves, new raw speed takes its slot
					hsum_q            <= hsum_w[SW-1:0];
					hist_vld_q[ptr_q] <= 1'b1;
					ptr_q             <= (ptr_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
					state_q           <= S_ABS;
				end
				S_ABS:   state_q <= S_RECIP;
				S_RECIP: state_q <= S_MEAS;
				S_MEAS:  state_q <= S_ERR;
				S_ERR:   state_q <= S_M0;
				S_M0: begin
					acc_q      <= acc_n[ACC_W-1:0];
					prev_err_q <= err_q;
					state_q    <= S_M1;
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		if (sample_beat) begin
			target_q <= sample.speed_setpoint;
			delta_q  <= d1[CB:0];
			rd_vld_q <= hist_vld_q[ptr_q];
		end
		if (state_q == S_SCALE) begin
			scaled_q <= delta_q * $signed({1'b0, scale_q});
		end
		if (state_q == S_ABS) begin
			neg_q <= hsum_q[SW-1];
			x_q   <= hsum_q[SW-1] ? xw[SW-1:0] : hsum_q[SW-1:0];
		end
		if (state_q == S_RECIP) begin
			qprod_q <= QW'(x_q) * QW'(RECIP);
		end
		if (state_q == S_MEAS) begin
			measured_q <= mq[SPEED_W-1:0];
		end
		if (state_q == S_ERR) begin
			err_q  <= err_n;
			derr_q <= DERR_W'(err_n) - DERR_W'(prev_err_q);
			zero_q <= (measured_q == '0) && (target_q == '0);
		end
		mul_q <= mul_a * mul_b;
		case (state_q)
			S_M1:    psum_q <= PSUM_W'(mul_q);
			S_M2:    psum_q <= psum_q + PSUM_W'(mul_q);
			S_M3:    psum_q <= psum_q + PSUM_W'(mul_q);
			default: ;
		endcase
		if (out_load) begin
			dir_q      <= (drive_n > 0);
			duty_q     <= drive_abs[15:0];
			drive_q    <= drive_n;
			meas_out_q <= measured_q;
		end
	end

	// ---- history memory ----
	always_ff @(posedge clk) begin
		if (state_q == S_HIST) begin
			hist_mem[ptr_q] <= raw;
		end
		if (sample_beat) begin
			rd_data_q <= hist_mem[ptr_q];
		end
	end

`ifndef ASSERT_OFF
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_W'(HISTORY_DEPTH - 1))
		else $error("history pointer beyond ring depth");

	a_acc_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == S_M0 && !$past(cfg_we)) |->
		(MUL_B_W'(acc_q) <= $signed({2'b00, ilim_q}) &&
		MUL_B_W'(acc_q) >= -$signed({2'b00, ilim_q})))
		else $error("accumulated error outside its clamp");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample_beat |=> !sample.ready)
		else $error("second sample taken while one is in flight");

	a_duty_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (DRIVE_W'(result.duty) ==
		((result.drive_value < 0) ? -result.drive_value : result.drive_value) &&
		result.direction_forward == (result.drive_value > 0)))
		else $error("duty or direction inconsistent with drive value");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !result.ready) |-> !out_load)
		else $error("result register loaded while a beat is pending");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench import wspl_pkg::*; ();

	// block sizes as elaborated, taken from the package defaults
	localparam int RING_DEPTH = HISTORY_DEPTH_DEF;
	localparam int COUNT_BITS = COUNTER_BITS_DEF;
	localparam longint COUNT_SPAN = 64'sd1 << COUNT_BITS;

	// sample beat to result beat, rounded up to the sequencer period
	localparam int LATENCY = 12;
	// cycles without any beat before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	localparam int REG_COUNT = int'(REG_SPEED_SCALE) + 1;
	// index past the last register, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic                      fwd;
		logic        [15:0]        duty;
		logic signed [DRIVE_W-1:0] drive;
		logic signed [SPEED_W-1:0] speed;
	} drive_beat_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	// one line of the directed script: a register write or a sample beat,
	// with the result typed in where it is obvious
	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic [15:0]            cnt;
		logic signed [15:0]     tgt;
		bit                     typed;
		drive_beat_t            want;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wspl_sample_if sample_bus ();
	wspl_result_if result_bus ();

	wheel_speed_pid_loop #(
		.HISTORY_DEPTH(RING_DEPTH),
		.COUNTER_BITS (COUNT_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (sample_bus),
		.result   (result_bus)
	);

	// loop model: register copies
	longint gain_p    = KP_RESET;
	longint gain_i    = KI_RESET;
	longint gain_d    = KD_RESET;
	longint lim_drive = DLIM_RESET;
	longint lim_acc   = ILIM_RESET;
	longint enc_mod   = MOD_RESET;
	longint spd_scale = SCALE_RESET;

	// loop model: control state, all zero out of reset
	longint enc_last = 0;
	longint speed_ring [RING_DEPTH] = '{default: 0};
	longint ring_sum = 0;
	longint err_acc  = 0;
	longint err_prev = 0;

	// results still owed by the block, oldest first
	drive_beat_t pending_drive [$];
	script_row_t script [$];

	int mismatches     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;

	// random trajectory: counter velocity and set point
	int gen_vel = 0;
	int gen_tgt = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_div(longint v, longint d);
		longint q;
		q = v / d;
		if ((v % d) != 0 && v < 0)
			q--;
		return q;
	endfunction

	function automatic longint clip_sym(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// out-of-range modulus falls back to the full counter span
	function automatic longint live_modulus();
		if (enc_mod < 2 || enc_mod > COUNT_SPAN)
			return COUNT_SPAN;
		return enc_mod;
	endfunction

	// one control tick of the speed loop; updates the model state
	function automatic drive_beat_t compute_drive(logic [15:0] count, logic signed [15:0] target);
		longint cnt, tgt, m, delta, raw, avg, err, psum, drv, mag;
		drive_beat_t beat;
		cnt = count & (COUNT_SPAN - 1);
		tgt = target;
		m = live_modulus();
		// single wrap correction around the half modulus
		delta = cnt - enc_last;
		if (delta > m / 2)
			delta -= m;
		else if (delta < -(m / 2))
			delta += m;
		enc_last = cnt;
		// q8.8 scale to speed units, saturated to 16 bits
		raw = floor_div(delta * spd_scale, 256);
		if (raw > 32767)
			raw = 32767;
		else if (raw < -32768)
			raw = -32768;
		// moving average over the history ring
		ring_sum -= speed_ring[RING_DEPTH-1];
		for (int i = RING_DEPTH - 1; i > 0; i--)
			speed_ring[i] = speed_ring[i-1];
		speed_ring[0] = raw;
		ring_sum += raw;
		avg = floor_div(ring_sum, RING_DEPTH);
		// standing still with a zero set point drops the integral
		if (avg == 0 && tgt == 0)
			err_acc = 0;
		err = tgt - avg;
		err_acc = clip_sym(err_acc + err, lim_acc);
		psum = gain_p * err + gain_i * err_acc + gain_d * (err - err_prev);
		err_prev = err;
		drv = clip_sym(floor_div(psum, 256), lim_drive);
		mag = (drv < 0) ? -drv : drv;
		beat.fwd = (drv > 0);
		beat.duty = mag[15:0];
		beat.drive = drv[DRIVE_W-1:0];
		beat.speed = avg[SPEED_W-1:0];
		return beat;
	endfunction

	function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		script.push_back('{ROW_WRITE, idx, data, 16'd0, 16'sd0, 1'b0, '0});
	endfunction

	function automatic void add_sample(logic [15:0] cnt, logic signed [15:0] tgt);
		script.push_back('{ROW_SAMPLE, '0, '0, cnt, tgt, 1'b0, '0});
	endfunction

	function automatic void add_known(logic [15:0] cnt, logic signed [15:0] tgt,
		drive_beat_t want);
		script.push_back('{ROW_SAMPLE, '0, '0, cnt, tgt, 1'b1, want});
	endfunction

	// mostly sane values, now and then zero, all ones or raw noise
	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(wspl_reg_t which);
		int unsigned v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = '1;
			2: v = $urandom;
			default: begin
				case (which)
					REG_KP_GAIN:         v = $urandom_range(4096);
					REG_KI_GAIN:         v = $urandom_range(512);
					REG_KD_GAIN:         v = $urandom_range(4096);
					REG_DRIVE_LIMIT:     v = $urandom_range(65535, 200);
					REG_INTEGRAL_LIMIT:  v = $urandom_range(200000);
					REG_ENCODER_MODULUS: v = $urandom_range(65536, 2);
					default:             v = $urandom_range(1024, 32);
				endcase
			end
		endcase
		return CFG_DATA_W'(v);
	endfunction

	// register write, entered and left on a falling edge, followed by an idle gap with cfg_we low
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			REG_KP_GAIN:         gain_p = data[GAIN_W-1:0];
			REG_KI_GAIN:         gain_i = data[GAIN_W-1:0];
			REG_KD_GAIN:         gain_d = data[GAIN_W-1:0];
			REG_DRIVE_LIMIT:     lim_drive = data[GAIN_W-1:0];
			REG_INTEGRAL_LIMIT:  lim_acc = data[ILIM_W-1:0];
			REG_ENCODER_MODULUS: enc_mod = data[MOD_W-1:0];
			REG_SPEED_SCALE:     spd_scale = data[GAIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
		@(negedge clk);
	endtask

	// stop offering and wait until every owed result beat has come back
	task automatic wait_drained;
		sample_bus.valid = 1'b0;
		while (pending_drive.size() != 0)
			@(negedge clk);
	endtask

	// offer one sample beat; valid stays high into the next call unless it idles
	task automatic send_sample(logic [15:0] cnt, logic signed [15:0] tgt, bit typed,
		drive_beat_t typed_want);
		drive_beat_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			sample_bus.valid = 1'b0;
			@(negedge clk);
		end
		sample_bus.valid = 1'b1;
		sample_bus.encoder_count = cnt;
		sample_bus.speed_setpoint = tgt;
		@(posedge clk);
		while (!sample_bus.ready)
			@(posedge clk);
		// model always advances; typed rows replace only the expectation
		predicted = compute_drive(cnt, tgt);
		pending_drive.push_back(typed ? typed_want : predicted);
		@(negedge clk);
	endtask

	// mostly a plausible wheel trajectory, some raw noise in between
	task automatic send_random_sample;
		longint m, nxt;
		logic [15:0] cnt;
		logic signed [15:0] tgt;
		m = live_modulus();
		if ($urandom_range(99) < 15) begin
			cnt = 16'($urandom);
			tgt = 16'($urandom);
		end else begin
			if ($urandom_range(15) == 0) begin
				gen_vel = int'($urandom_range(int'(m / 4)));
				if ($urandom_range(1) == 1)
					gen_vel = -gen_vel;
			end
			if ($urandom_range(19) == 0) begin
				if ($urandom_range(1) == 1)
					gen_tgt = int'($urandom_range(65535)) - 32768;
				else
					gen_tgt = int'($urandom_range(2000)) - 1000;
			end
			// wheel at rest with zero set point, integral reset path
			if ($urandom_range(39) == 0) begin
				gen_vel = 0;
				gen_tgt = 0;
			end
			nxt = ((enc_last + gen_vel) % m + m) % m;
			cnt = nxt[15:0];
			tgt = gen_tgt[15:0];
		end
		send_sample(cnt, tgt, 1'b0, '0);
	endtask

	// idle, reprogram every register, then run random beats at the given pressure
	task automatic run_phase(int send_pct, int stall_pct, int n_items, int hold);
		wait_drained;
		for (int i = 0; i < REG_COUNT; i++)
			write_reg(CFG_IDX_W'(i), pick_reg_value(wspl_reg_t'(i)));
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		hold_left = hold;
		repeat (n_items)
			send_random_sample;
	endtask

	// result side ready, with an optional long hold-off counted down here
	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_bus.ready = 1'b0;
				hold_left--;
			end else begin
				result_bus.ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin : drive_check
		drive_beat_t got, want;
		if (result_bus.valid && result_bus.ready) begin
			got = '{result_bus.direction_forward, result_bus.duty, result_bus.drive_value,
				result_bus.measured_speed};
			if (pending_drive.size() == 0) begin
				$display("%0t: result beat with nothing owed: fwd=%0b duty=%0d drive=%0d speed=%0d",
					$time, got.fwd, got.duty, got.drive, got.speed);
				mismatches++;
			end else begin
				want = pending_drive.pop_front();
				if (got !== want) begin
					$display("%0t: expected fwd=%0b duty=%0d drive=%0d speed=%0d", $time,
						want.fwd, want.duty, want.drive, want.speed);
					$display("%0t:   actual fwd=%0b duty=%0d drive=%0d speed=%0d", $time,
						got.fwd, got.duty, got.drive, got.speed);
					mismatches++;
				end
			end
		end
	end

	// hang detector: no beat on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("wheel_speed_pid_loop: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_bus.valid = 1'b0;
		sample_bus.encoder_count = '0;
		sample_bus.speed_setpoint = '0;

		// reset defaults: both clamps zero, so drive is stuck at zero
		add_known(16'd0, 16'sd0, '{1'b0, 16'd0, 17'sd0, 16'sd0});
		add_known(16'd256, 16'sd32767, '{1'b0, 16'd0, 17'sd0, 16'sd32});
		// wraps backwards by 257, average floors to -1
		add_known(16'd65535, 16'sh8000, '{1'b0, 16'd0, 17'sd0, -16'sd1});
		add_sample(16'd65535, 16'sd0);
		// full gains and limits: drive pinned at both rails
		add_write(REG_KP_GAIN, 24'd65535);
		add_write(REG_KI_GAIN, 24'd65535);
		add_write(REG_KD_GAIN, 24'd65535);
		add_write(REG_DRIVE_LIMIT, 24'd65535);
		add_write(REG_INTEGRAL_LIMIT, 24'hFFFFFF);
		add_known(16'd65535, 16'sd32767, '{1'b1, 16'd65535, 17'sd65535, -16'sd1});
		add_known(16'd65535, 16'sh8000, '{1'b0, 16'd65535, -17'sd65535, -16'sd1});
		// modulus below two falls back to full span, max scale saturates raw speed
		add_write(REG_ENCODER_MODULUS, 24'd1);
		add_write(REG_SPEED_SCALE, 24'd65535);
		add_sample(16'd32768, 16'sd0);
		add_sample(16'd0, 16'sd100);
		// short modulus, counts at and beyond it
		add_write(REG_ENCODER_MODULUS, 24'd1000);
		add_write(REG_SPEED_SCALE, 24'd256);
		add_write(REG_DRIVE_LIMIT, 24'd300);
		add_write(REG_KP_GAIN, 24'd512);
		add_write(REG_KI_GAIN, 24'd32);
		add_write(REG_KD_GAIN, 24'd256);
		add_write(REG_INTEGRAL_LIMIT, 24'd2000);
		add_sample(16'd999, 16'sd500);
		add_sample(16'd5000, 16'sd500);
		add_sample(16'd65535, -16'sd500);
		// oversize modulus is masked then falls back; spare index is ignored
		add_write(REG_ENCODER_MODULUS, 24'hFFFFFF);
		add_write(REG_SPARE, 24'd2);
		add_sample(16'd40000, 16'sd0);
		add_sample(16'd7000, 16'sd0);
		// smallest modulus
		add_write(REG_ENCODER_MODULUS, 24'd2);
		add_sample(16'd3, 16'sd0);
		add_sample(16'd3, 16'sd0);
		// zero integral clamp with live drive, then integral reset at standstill
		add_write(REG_ENCODER_MODULUS, 24'd65536);
		add_write(REG_INTEGRAL_LIMIT, 24'd0);
		add_write(REG_DRIVE_LIMIT, 24'd1000);
		add_write(REG_KP_GAIN, 24'd256);
		add_write(REG_KI_GAIN, 24'd256);
		add_write(REG_KD_GAIN, 24'd0);
		add_sample(16'd3, 16'sd1000);
		add_sample(16'd3, 16'sd1000);
		add_write(REG_INTEGRAL_LIMIT, 24'd5000);
		repeat (5)
			add_sample(16'd3, 16'sd40);
		add_sample(16'd3, 16'sd0);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				wait_drained;
				write_reg(script[i].idx, script[i].data);
			end else begin
				send_sample(script[i].cnt, script[i].tgt, script[i].typed, script[i].want);
			end
		end

		// random phases: no idling, sender idle, receiver stalling, both
		run_phase(0, 0, 130, 0);
		run_phase(75, 0, 130, 0);
		run_phase(0, 75, 130, 0);
		run_phase(33, 33, 130, 0);
		// receiver holds off while beats keep coming, input backs up
		run_phase(0, 0, 30, 400);

		wait_drained;
		repeat (3 * LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("wheel_speed_pid_loop: match");
		else
			$display("wheel_speed_pid_loop: mismatch");
		$finish;
	end

endmodule
